>>> design/gelu_pkg.sv
package gelu_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // internal fixed-point formats
  localparam int QX = 24;
  localparam int QF = 30;

  localparam logic signed [31:0] K_C1      = 32'sd856722024;
  localparam logic signed [31:0] K_C2      = 32'sd48012366;
  localparam logic signed [31:0] K_LN2     = 32'sd744261118;
  localparam logic signed [31:0] K_INV_LN2 = 32'sd1549082005;
  localparam logic signed [31:0] Y_LIM     = 32'sd1476395008;  // 88 in Q24

  localparam int POLY_N = 6;
  localparam logic signed [32:0] K_P6 = 33'sd1491308;
  // constant added after each Horner step
  localparam logic signed [32:0] POLY_K [POLY_N] = '{
    33'sd8947849, 33'sd44739243, 33'sd178956971, 33'sd536870912,
    33'sd1073741824, 33'sd1073741824
  };

  // reciprocal 2^44 / q, restoring divider
  localparam int DIV_QUO_BITS   = 16;
  localparam int DIV_STEPS      = 2;
  localparam int DIV_STAGES     = DIV_QUO_BITS / DIV_STEPS;
  localparam int DIV_DEN_W      = 34;
  localparam int DIV_REM_W      = DIV_DEN_W + 1;
  localparam int DIV_NUM_LOG2   = 44;
  localparam logic [DIV_REM_W-1:0] DIV_REM_INIT =
    DIV_REM_W'(64'd1 << (DIV_NUM_LOG2 - DIV_QUO_BITS));

endpackage

>>> design/gelu_recip_div.sv
module gelu_recip_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [gelu_pkg::DIV_DEN_W-1:0]       den_in,
  output logic [gelu_pkg::DIV_DEN_W-1:0]       den_out,
  output logic [gelu_pkg::DIV_QUO_BITS-1:0]    quo_out
);

  localparam int NS = gelu_pkg::DIV_STAGES;
  localparam int DW = gelu_pkg::DIV_DEN_W;
  localparam int RW = gelu_pkg::DIV_REM_W;
  localparam int QB = gelu_pkg::DIV_QUO_BITS;

  logic [RW-1:0] rem      [NS];
  logic [QB-1:0] quo      [NS];
  logic [DW-1:0] den      [NS];
  logic [RW-1:0] rem_next [NS];
  logic [QB-1:0] quo_next [NS];

  always_comb begin
    logic [RW-1:0] r;
    logic [QB-1:0] qv;
    logic [DW-1:0] d;
    for (int j = 0; j < NS; j++) begin
      r  = (j == 0) ? gelu_pkg::DIV_REM_INIT : rem[(j == 0) ? 0 : j - 1];
      qv = (j == 0) ? '0 : quo[(j == 0) ? 0 : j - 1];
      d  = (j == 0) ? den_in : den[(j == 0) ? 0 : j - 1];
      for (int b = 0; b < gelu_pkg::DIV_STEPS; b++) begin
        r = r << 1;
        if (r >= {1'b0, d}) begin
          r  = r - {1'b0, d};
          qv = {qv[QB-2:0], 1'b1};
        end else begin
          qv = {qv[QB-2:0], 1'b0};
        end
      end
      rem_next[j] = r;
      quo_next[j] = qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        rem[j] <= rem_next[j];
        quo[j] <= quo_next[j];
        den[j] <= (j == 0) ? den_in : den[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign den_out = den[NS-1];
  assign quo_out = quo[NS-1];

endmodule

>>> design/gelu_tanh_activation_top.sv
// GELU activation, tanh form, on signed fixed-point values.
// Input stream: s_tvalid/s_tready/s_tdata/s_tlast, one value per beat.
// Output stream: m_tvalid/m_tready/m_tdata/m_tlast, one result per beat,
// in input order, tlast copied from the matching input beat.
// Each value runs through a 26-stage pipeline: square, cube, inner
// argument, exp range reduction, six Horner steps, an 8-stage restoring
// divider for the reciprocal seed, one Newton step and the final product.
// Throughput is one beat per cycle while the receiver accepts results, as the
// multiplier and divider stages are fully pipelined.
// When the receiver stalls with a result waiting in the output register,
// the whole pipeline holds and s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; no output appears until
// new input beats have passed through.
module gelu_tanh_activation_top #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,   // value_in
  input  logic                                 s_tlast,   // last_in
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_tdata,   // value_out
  output logic                                 m_tlast    // last_out
);

  localparam int TDW    = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int ST_T   = 5;
  localparam int ST_F   = 6;
  localparam int ST_P0  = 7;
  localparam int ST_Q   = ST_P0 + gelu_pkg::POLY_N;
  localparam int ST_DIV = ST_Q + gelu_pkg::DIV_STAGES;
  localparam int ST_E   = ST_DIV + 1;
  localparam int ST_R   = ST_E + 1;
  localparam int ST_TH  = ST_R + 1;
  localparam int NST    = ST_TH + 2;
  localparam int PN     = gelu_pkg::POLY_N;

  localparam logic signed [33:0] XLIM = 34'sd16 <<< FRAC_BITS;
  localparam logic signed [DATA_WIDTH+1:0] RES_MAX = (DATA_WIDTH+2)'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [DATA_WIDTH+1:0] RES_MIN = (DATA_WIDTH+2)'(-(64'sd1 <<< (DATA_WIDTH-1)));

  logic [NST-1:0] vld;
  logic           en;

  logic signed [DATA_WIDTH-1:0] xs_line [NST-1];
  logic                         last_line [NST];
  logic signed [8:0]            tl [ST_T:ST_R];

  logic signed [29:0] xq0, xq1, xq2;
  logic signed [33:0] x2_1;
  logic signed [37:0] x3_2;
  logic signed [33:0] s3;
  logic signed [31:0] y4, y5;
  logic signed [31:0] f6;
  logic signed [32:0] pol_p [PN];
  logic signed [31:0] pol_f [PN];
  logic [33:0]        q13;
  logic [33:0]        qd;
  logic [gelu_pkg::DIV_QUO_BITS-1:0] quo, quo22;
  logic [31:0]        e22;
  logic [33:0]        r23;
  logic [31:0]        th24;
  logic [DATA_WIDTH-1:0] res25;

  logic signed [29:0] xq0_next;
  logic signed [33:0] x2_next, s_next;
  logic signed [37:0] x3_next;
  logic signed [31:0] y_next, f_next;
  logic signed [8:0]  t_next;
  logic signed [32:0] pol_next [PN];
  logic [33:0]        q_next, r_next;
  logic [31:0]        e_next, th_next;
  logic [DATA_WIDTH-1:0] res_next;

  assign en       = !vld[NST-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NST-1];
  assign m_tlast  = last_line[NST-1];
  assign m_tdata  = TDW'(res25);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage 0: clamp for the tanh argument, move to Q24
  always_comb begin
    logic signed [DATA_WIDTH-1:0] xs_in;
    logic signed [33:0] xw, xc, xsh;
    xs_in = s_tdata[DATA_WIDTH-1:0];
    xw    = 34'(xs_in);
    xc    = (xw < -XLIM) ? -XLIM : ((xw > XLIM) ? XLIM : xw);
    xsh   = xc <<< (gelu_pkg::QX - FRAC_BITS);
    xq0_next = xsh[29:0];
  end

  // stages 1..6: x^2, x^3, inner sum, u and y, t, f
  always_comb begin
    logic signed [59:0] m1;
    logic signed [63:0] m2;
    logic signed [69:0] m3;
    logic signed [65:0] m4;
    logic signed [36:0] y2;
    logic signed [63:0] m5;
    logic signed [40:0] d6;
    m1 = xq0 * xq0;
    m1 = m1 + (60'sd1 <<< 23);
    x2_next = m1[57:24];
    m2 = x2_1 * xq1;
    m2 = m2 + (64'sd1 <<< 23);
    x3_next = m2[61:24];
    m3 = gelu_pkg::K_C2 * x3_2;
    m3 = m3 + (70'sd1 <<< 29);
    s_next = 34'(xq2) + m3[63:30];
    m4 = gelu_pkg::K_C1 * s3;
    m4 = m4 + (66'sd1 <<< 29);
    y2 = {m4[65:30], 1'b0};
    if (y2 > 37'(gelu_pkg::Y_LIM)) begin
      y_next = gelu_pkg::Y_LIM;
    end else if (y2 < -37'(gelu_pkg::Y_LIM)) begin
      y_next = -gelu_pkg::Y_LIM;
    end else begin
      y_next = y2[31:0];
    end
    m5 = y4 * gelu_pkg::K_INV_LN2;
    m5 = m5 + (64'sd1 <<< 53);
    t_next = m5[62:54];
    d6 = (41'(y5) <<< 6) - 41'(tl[ST_T]) * 41'(gelu_pkg::K_LN2);
    f_next = d6[31:0];
  end

  // Horner steps for exp(f)
  always_comb begin
    logic signed [32:0] pp;
    logic signed [31:0] pf;
    logic signed [64:0] m;
    for (int k = 0; k < PN; k++) begin
      pp = (k == 0) ? gelu_pkg::K_P6 : pol_p[(k == 0) ? 0 : k - 1];
      pf = (k == 0) ? f6 : pol_f[(k == 0) ? 0 : k - 1];
      m  = pp * pf;
      m  = m + (65'sd1 <<< 29);
      pol_next[k] = m[62:30] + gelu_pkg::POLY_K[k];
    end
  end

  // denominator 1 + e^y, scaled by 2^-t when t >= 0
  always_comb begin
    logic signed [8:0] t;
    logic [8:0]  nt;
    logic [5:0]  sh;
    logic [33:0] p;
    t = tl[ST_Q-1];
    p = 34'(pol_p[PN-1]);
    nt = -t;
    sh = (nt > 9'd32) ? 6'd32 : nt[5:0];
    if (!t[8]) begin
      q_next = p + ((t < 9'sd31) ? ((34'd1 << 30) >> t[4:0]) : 34'd0);
    end else begin
      q_next = (34'd1 << 30) + ((p + (34'd1 << (sh - 6'd1))) >> sh);
    end
  end

  gelu_recip_div u_div (
    .clk     (clk),
    .en      (en),
    .den_in  (q13),
    .den_out (qd),
    .quo_out (quo)
  );

  // Newton step, final scale, tanh bound and output product
  always_comb begin
    logic [49:0] mq;
    logic [47:0] mr;
    logic signed [8:0] t;
    logic [5:0]  sh;
    logic [33:0] r2;
    logic signed [35:0] thw;
    logic signed [DATA_WIDTH+32:0] mo;
    logic signed [DATA_WIDTH+1:0] rv;
    mq = qd * quo;
    mq = mq + (50'd1 << 13);
    e_next = 32'h8000_0000 - mq[45:14];
    mr = quo22 * e22;
    mr = mr + (48'd1 << 13);
    r_next = mr[47:14];
    t  = tl[ST_R];
    sh = (t > 9'sd32) ? 6'd32 : t[5:0];
    if (!t[8] && (t != 9'sd0)) begin
      r2 = (r23 + (34'd1 << (sh - 6'd1))) >> sh;
    end else begin
      r2 = r23;
    end
    thw = 36'sh0_8000_0000 - $signed({1'b0, r2, 1'b0});
    th_next = thw[35] ? 32'd0 : thw[31:0];
    mo = xs_line[NST-2] * $signed({1'b0, th24});
    mo = mo + ((DATA_WIDTH+33)'(1) <<< 30);
    rv = mo[DATA_WIDTH+32:31];
    if (rv > RES_MAX) begin
      res_next = RES_MAX[DATA_WIDTH-1:0];
    end else if (rv < RES_MIN) begin
      res_next = RES_MIN[DATA_WIDTH-1:0];
    end else begin
      res_next = rv[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_line[0]   <= s_tdata[DATA_WIDTH-1:0];
      last_line[0] <= s_tlast;
      for (int k = 1; k < NST - 1; k++) begin
        xs_line[k] <= xs_line[k-1];
      end
      for (int k = 1; k < NST; k++) begin
        last_line[k] <= last_line[k-1];
      end
      xq0  <= xq0_next;
      x2_1 <= x2_next;
      xq1  <= xq0;
      x3_2 <= x3_next;
      xq2  <= xq1;
      s3   <= s_next;
      y4   <= y_next;
      y5   <= y4;
      tl[ST_T] <= t_next;
      for (int k = ST_T + 1; k <= ST_R; k++) begin
        tl[k] <= tl[k-1];
      end
      f6 <= f_next;
      for (int k = 0; k < PN; k++) begin
        pol_p[k] <= pol_next[k];
        pol_f[k] <= (k == 0) ? f6 : pol_f[(k == 0) ? 0 : k - 1];
      end
      q13   <= q_next;
      e22   <= e_next;
      quo22 <= quo;
      r23   <= r_next;
      th24  <= th_next;
      res25 <= res_next;
    end
  end

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");
  a_den_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_Q] |-> (q13 >= 34'd751619276))
    else $error("reciprocal denominator below range");
  a_newton_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_E] |-> (e22 >= 32'h4000_0000))
    else $error("reciprocal seed too large");
`endif

endmodule
